// ===== src/tsp_pkg.sv =====
package tsp_pkg;

    // Default width of decoded type and length numbers.
    localparam int TSP_VALUE_BITS_DEF = 32;

    // First-byte markers of the variable-number form.
    localparam logic [7:0] VN_MARK_2 = 8'hFD;
    localparam logic [7:0] VN_MARK_4 = 8'hFE;
    localparam logic [7:0] VN_MARK_8 = 8'hFF;

    localparam logic [4:0] HDR_COUNT_MAX = 5'd18;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_VALUE  = 1'b1;

    typedef enum logic [2:0] {
        PH_TYPE_FIRST = 3'd0,
        PH_TYPE_EXTRA = 3'd1,
        PH_LEN_FIRST  = 3'd2,
        PH_LEN_EXTRA  = 3'd3,
        PH_VALUE      = 3'd4,
        PH_DROP       = 3'd5
    } t_phase;

    // Parser control state that travels between the top level and the decoder.
    typedef struct packed {
        t_phase     phase;
        logic [3:0] extra_left;
        logic [4:0] hdr_count;
        logic       overflow;
    } t_ctl;

    typedef struct packed {
        logic        out_kind;
        logic [31:0] tlv_type;
        logic [31:0] tlv_length;
        logic [4:0]  header_bytes;
        logic [7:0]  value_byte;
        logic        element_last;
        logic        parse_error;
    } t_result;

    localparam t_ctl CTL_RESET = '{phase: PH_TYPE_FIRST, extra_left: 4'd0,
                                   hdr_count: 5'd0, overflow: 1'b0};

    // Number of big-endian bytes that follow a marker byte.
    function automatic logic [3:0] extra_for(input logic [7:0] b);
        logic [3:0] n;
        begin
            if (b == VN_MARK_2) begin
                n = 4'd2;
            end else if (b == VN_MARK_4) begin
                n = 4'd4;
            end else begin
                n = 4'd8;
            end
            return n;
        end
    endfunction

endpackage

// ===== src/tsp_stream_if.sv =====
interface tsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface tsp_out_if;
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [31:0] tlv_type;
    logic [31:0] tlv_length;
    logic [4:0]  header_bytes;
    logic [7:0]  value_byte;
    logic        element_last;
    logic        parse_error;

    modport source (output valid, output out_kind, output tlv_type, output tlv_length,
                    output header_bytes, output value_byte, output element_last,
                    output parse_error, input ready);
    modport sink   (input valid, input out_kind, input tlv_type, input tlv_length,
                    input header_bytes, input value_byte, input element_last,
                    input parse_error, output ready);
endinterface

// ===== src/tsp_decode.sv =====
module tsp_decode
    import tsp_pkg::*;
#(
    parameter int VALUE_BITS = TSP_VALUE_BITS_DEF,
    parameter int ACC_BITS   = (VALUE_BITS > 32) ? VALUE_BITS : 32
) (
    input  t_ctl                  i_ctl,
    input  logic [ACC_BITS-1:0]   i_type_acc,
    input  logic [ACC_BITS-1:0]   i_len_acc,
    input  logic [VALUE_BITS-1:0] i_val_left,
    input  logic [7:0]            i_byte,
    input  logic                  i_frame_start,
    output t_ctl                  o_ctl,
    output logic [ACC_BITS-1:0]   o_type_acc,
    output logic [ACC_BITS-1:0]   o_len_acc,
    output logic [VALUE_BITS-1:0] o_val_left,
    output logic                  o_res_valid,
    output t_result               o_res
);

    t_ctl                  cur;
    logic [ACC_BITS-1:0]   ta;
    logic [ACC_BITS-1:0]   la;
    logic [VALUE_BITS-1:0] vl;
    logic                  done;
    logic                  last;
    logic                  err;
    logic                  kind;

    // A frame start makes the byte the first byte of a fresh stream.
    always_comb begin
        cur = i_frame_start ? CTL_RESET : i_ctl;
        ta  = i_type_acc;
        la  = i_len_acc;
        vl  = i_val_left;
        done = 1'b0;
        last = 1'b0;
        err  = 1'b0;
        kind = KIND_HEADER;

        case (cur.phase)
            PH_TYPE_FIRST: begin
                cur.hdr_count = 5'd1;
                cur.overflow  = 1'b0;
                la = '0;
                vl = '0;
                if (i_byte < VN_MARK_2) begin
                    ta = {{(ACC_BITS-8){1'b0}}, i_byte};
                    cur.phase = PH_LEN_FIRST;
                end else begin
                    ta = '0;
                    cur.extra_left = extra_for(i_byte);
                    cur.phase = PH_TYPE_EXTRA;
                end
            end
            PH_TYPE_EXTRA: begin
                cur.hdr_count = cur.hdr_count + 5'd1;
                // Any set bit that the shift moves to or past VALUE_BITS is an overflow.
                if (|ta[ACC_BITS-1:VALUE_BITS-8]) begin
                    cur.overflow = 1'b1;
                end
                ta = {ta[ACC_BITS-9:0], i_byte};
                cur.extra_left = cur.extra_left - 4'd1;
                if (cur.extra_left == 4'd0) begin
                    if (cur.overflow) begin
                        done = 1'b1;
                        last = 1'b1;
                        err  = 1'b1;
                        cur.phase = PH_DROP;
                    end else begin
                        cur.phase = PH_LEN_FIRST;
                    end
                end
            end
            PH_LEN_FIRST: begin
                cur.hdr_count = cur.hdr_count + 5'd1;
                if (i_byte < VN_MARK_2) begin
                    la   = {{(ACC_BITS-8){1'b0}}, i_byte};
                    done = 1'b1;
                    if (i_byte == 8'd0) begin
                        last = 1'b1;
                        cur.phase = PH_TYPE_FIRST;
                    end else begin
                        vl = VALUE_BITS'(i_byte);
                        cur.phase = PH_VALUE;
                    end
                end else begin
                    cur.extra_left = extra_for(i_byte);
                    cur.phase = PH_LEN_EXTRA;
                end
            end
            PH_LEN_EXTRA: begin
                cur.hdr_count = cur.hdr_count + 5'd1;
                if (|la[ACC_BITS-1:VALUE_BITS-8]) begin
                    cur.overflow = 1'b1;
                end
                la = {la[ACC_BITS-9:0], i_byte};
                cur.extra_left = cur.extra_left - 4'd1;
                if (cur.extra_left == 4'd0) begin
                    done = 1'b1;
                    if (cur.overflow) begin
                        last = 1'b1;
                        err  = 1'b1;
                        cur.phase = PH_DROP;
                    end else if (la == '0) begin
                        last = 1'b1;
                        cur.phase = PH_TYPE_FIRST;
                    end else begin
                        vl = la[VALUE_BITS-1:0];
                        cur.phase = PH_VALUE;
                    end
                end
            end
            PH_VALUE: begin
                vl   = vl - VALUE_BITS'(1);
                done = 1'b1;
                kind = KIND_VALUE;
                last = (vl == '0);
                if (last) begin
                    cur.phase = PH_TYPE_FIRST;
                end
            end
            default: begin
                // Dropping bytes until the next frame start.
            end
        endcase
    end

    assign o_ctl       = cur;
    assign o_type_acc  = ta;
    assign o_len_acc   = la;
    assign o_val_left  = vl;
    assign o_res_valid = done;

    always_comb begin
        o_res.out_kind     = kind;
        o_res.tlv_type     = ta[31:0];
        o_res.tlv_length   = la[31:0];
        o_res.header_bytes = cur.hdr_count;
        o_res.value_byte   = (kind == KIND_VALUE) ? i_byte : 8'd0;
        o_res.element_last = last;
        o_res.parse_error  = err;
    end

endmodule

// ===== src/tlv_stream_parser.sv =====
// Byte-serial parser for a stream of back-to-back flat TLV elements whose type
// and length numbers use the variable-number form (a byte below 0xFD, or 0xFD,
// 0xFE or 0xFF followed by 2, 4 or 8 big-endian bytes). Each input word is one
// stream byte; frame_start on a word restarts the parser at a type first byte.
// A completed header yields one header word with type, length and header size;
// each value byte then comes out as one value word, the last one flagged with
// element_last. A zero-length element ends with its header word. A number that
// does not fit in VALUE_BITS gives one error word, after which bytes are
// silently dropped until the next frame_start. The parser takes one byte per
// clock unless back-pressure stalls it: a byte is captured in an input
// register, decoded by one level of shallow logic against the parser state,
// and its result word (if any) lands in an output register when the byte
// moves on. Back-pressure on the output only stalls the input when the output
// register is full and the waiting byte would produce another word. No byte
// is taken while reset is asserted.
module tlv_stream_parser
    import tsp_pkg::*;
#(
    parameter int VALUE_BITS = TSP_VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsp_in_if.sink    i_in,
    tsp_out_if.source o_out
);

    // Accumulators keep at least 32 bits so the outputs carry the low 32 bits
    // of a decoded number even when VALUE_BITS is narrower.
    localparam int ACC_BITS = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    // Input register.
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_fs;

    // Parser state.
    t_ctl                  r_ctl;
    logic [ACC_BITS-1:0]   r_type_acc;
    logic [ACC_BITS-1:0]   r_len_acc;
    logic [VALUE_BITS-1:0] r_val_left;

    // Result register.
    logic    r_out_valid;
    t_result r_out;

    t_ctl                  n_ctl;
    logic [ACC_BITS-1:0]   n_type_acc;
    logic [ACC_BITS-1:0]   n_len_acc;
    logic [VALUE_BITS-1:0] n_val_left;
    logic                  res_valid;
    t_result               res;

    logic out_free;
    logic s1_fire;

    tsp_decode #(
        .VALUE_BITS (VALUE_BITS),
        .ACC_BITS   (ACC_BITS)
    ) u_decode (
        .i_ctl         (r_ctl),
        .i_type_acc    (r_type_acc),
        .i_len_acc     (r_len_acc),
        .i_val_left    (r_val_left),
        .i_byte        (r_s1_byte),
        .i_frame_start (r_s1_fs),
        .o_ctl         (n_ctl),
        .o_type_acc    (n_type_acc),
        .o_len_acc     (n_len_acc),
        .o_val_left    (n_val_left),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // The held byte moves on when it makes no word or the result slot is free.
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_fire    = r_s1_valid && (out_free || !res_valid);
    assign i_in.ready = i_rst_n && (!r_s1_valid || s1_fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctl       <= CTL_RESET;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_fire) begin
                r_ctl <= n_ctl;
            end
            if (s1_fire && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_byte <= i_in.data_byte;
            r_s1_fs   <= i_in.frame_start;
        end
        if (s1_fire) begin
            r_type_acc <= n_type_acc;
            r_len_acc  <= n_len_acc;
            r_val_left <= n_val_left;
        end
        if (s1_fire && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_kind     = r_out.out_kind;
    assign o_out.tlv_type     = r_out.tlv_type;
    assign o_out.tlv_length   = r_out.tlv_length;
    assign o_out.header_bytes = r_out.header_bytes;
    assign o_out.value_byte   = r_out.value_byte;
    assign o_out.element_last = r_out.element_last;
    assign o_out.parse_error  = r_out.parse_error;

    // A result word that is not taken must still be there next cycle.
    a_no_lost_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid)
        else $error("result word lost while stalled");

    // An error word is a header-type word that closes the element.
    a_error_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.parse_error |->
            r_out.element_last && (r_out.out_kind == KIND_HEADER))
        else $error("error word malformed");

    // While value bytes are expected the remaining count is never zero.
    a_value_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.phase == PH_VALUE |-> r_val_left != '0)
        else $error("value phase with zero bytes left");

    // The header never spans more than two nine-byte numbers.
    a_hdr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.hdr_count <= HDR_COUNT_MAX)
        else $error("header byte count out of range");

endmodule
